// ===== rtl/core/dod_pkg.sv =====
// Shared constants, types and helper functions of the divider ohmmeter readout.
package dod_pkg;

    // Register widths and configuration port
    localparam int REF_W     = 20;
    localparam int VPC_W     = 12;
    localparam int SUP_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_OHMS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTS_PER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_LEVEL    = 2'd2;

    localparam logic [REF_W-1:0] RESET_REFERENCE_OHMS  = 20'd10000;
    localparam logic [VPC_W-1:0] RESET_VOLTS_PER_COUNT = 12'd488;
    localparam logic [SUP_W-1:0] RESET_SUPPLY_LEVEL    = 20'd500000;

    // Default values of the top level parameters
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_DIGITS_DEF  = 7;

    // Divider: product of voltage and reference over a 20-bit denominator
    localparam int PW         = SUP_W + REF_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_ITERS  = PW / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

    // Binary to BCD conversion bits per cycle
    localparam int BCD_STEPS = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Character codes
    localparam int CHAR_W = 8;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_OHM   = 8'd244;

    localparam int TAIL_LEN = 5;

    typedef struct packed {
        logic             sat;
        logic [PW-1:0]    prod;
        logic [SUP_W-1:0] den;
    } t_job;

    function automatic longint unsigned pow10(input int n);
        longint unsigned m;
        m = 1;
        for (int i = 0; i < n; i++) begin
            m = m * 10;
        end
        return m;
    endfunction

    // Fixed suffix ".00 " and the ohm sign, in order
    function automatic logic [CHAR_W-1:0] tail_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            3'd0:    c = CHAR_DOT;
            3'd1:    c = CHAR_ZERO;
            3'd2:    c = CHAR_ZERO;
            3'd3:    c = CHAR_SPACE;
            3'd4:    c = CHAR_OHM;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/dod_front.sv =====
// Front end: accepts samples and forms the numerator and denominator of each request.
module dod_front #(
    parameter int SAMPLE_BITS = dod_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic [dod_pkg::REF_W-1:0]  i_reference_ohms,
    input  logic [dod_pkg::VPC_W-1:0]  i_volts_per_count,
    input  logic [dod_pkg::SUP_W-1:0]  i_supply_level,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output dod_pkg::t_job              o_job
);

    localparam int VW = SAMPLE_BITS + dod_pkg::VPC_W;

    logic                r_s1_valid;
    logic [VW-1:0]       r_volt;
    logic                r_s2_valid;
    dod_pkg::t_job       r_job;
    logic                s1_ready;
    logic                s2_ready;
    dod_pkg::t_job       n_job;

    assign s2_ready = !r_s2_valid || i_job_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign o_job_valid = r_s2_valid;
    assign o_job       = r_job;

    // Saturate when the sample voltage reaches the supply
    always_comb begin
        n_job.sat  = r_volt >= VW'(i_supply_level);
        n_job.den  = i_supply_level - r_volt[dod_pkg::SUP_W-1:0];
        n_job.prod = r_volt[dod_pkg::SUP_W-1:0] * i_reference_ohms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_volt <= VW'(i_sample) * VW'(i_volts_per_count);
        end
        if (s2_ready && r_s1_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/core/dod_queue.sv =====
// Short queue of pending divide requests between front and back.
module dod_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dod_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output dod_pkg::t_job o_job
);

    dod_pkg::t_job                r_slot [dod_pkg::QUEUE_DEPTH];
    logic [dod_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [dod_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [dod_pkg::QPTR_W:0]     r_count;
    logic                         push;
    logic                         pop;

    assign o_ready = r_count != (dod_pkg::QPTR_W + 1)'(dod_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/dod_back.sv =====
// Back end: iterative divider, saturation and binary to BCD conversion.
module dod_back #(
    parameter int MAX_DIGITS = dod_pkg::MAX_DIGITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    output logic                      o_job_ready,
    input  dod_pkg::t_job             i_job,
    output logic                      o_digits_valid,
    input  logic                      i_digits_ready,
    output logic [4*MAX_DIGITS-1:0]   o_digits
);

    localparam int PW        = dod_pkg::PW;
    localparam int DW        = dod_pkg::SUP_W;
    localparam int CW        = $clog2(dod_pkg::pow10(MAX_DIGITS));
    localparam int BCD_ITERS = (CW + dod_pkg::BCD_STEPS - 1) / dod_pkg::BCD_STEPS;
    localparam int CBW       = BCD_ITERS * dod_pkg::BCD_STEPS;
    localparam int BCD_CNT_W = (BCD_ITERS > 1) ? $clog2(BCD_ITERS) : 1;
    localparam int BW        = 4 * MAX_DIGITS;
    localparam logic [PW-1:0] CAP = PW'(dod_pkg::pow10(MAX_DIGITS) - 1);

    // Divider
    logic                          r_div_busy;
    logic                          r_div_done;
    logic [dod_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [DW-1:0]                 r_rem;
    logic [PW-1:0]                 r_quo;
    logic [DW-1:0]                 r_den;
    logic                          r_sat;
    logic [DW-1:0]                 n_rem;
    logic [PW-1:0]                 n_quo;

    // BCD converter
    logic                          r_bcd_busy;
    logic                          r_bcd_done;
    logic [BCD_CNT_W-1:0]          r_bcd_cnt;
    logic [CBW-1:0]                r_bin;
    logic [BW-1:0]                 r_bcd;
    logic [CBW-1:0]                n_bin;
    logic [BW-1:0]                 n_bcd;

    logic                          bcd_ready;
    logic                          bcd_take;
    logic                          job_take;
    logic [CW-1:0]                 value;

    assign bcd_ready   = !r_bcd_busy || (r_bcd_done && i_digits_ready);
    assign bcd_take    = r_div_done && bcd_ready;
    assign o_job_ready = !r_div_busy || bcd_take;
    assign job_take    = i_job_valid && o_job_ready;

    assign o_digits_valid = r_bcd_done;
    assign o_digits       = r_bcd;

    // Clamp to the largest value that fits the display
    assign value = (r_sat || r_quo > CAP) ? CAP[CW-1:0] : r_quo[CW-1:0];

    // Restoring division, several quotient bits per cycle
    always_comb begin
        logic [DW:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < dod_pkg::DIV_STEPS; k++) begin
            t     = {n_rem, n_quo[PW-1]};
            n_quo = {n_quo[PW-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                n_rem    = DW'(t - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[DW-1:0];
            end
        end
    end

    // Double dabble, several bits per cycle
    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        for (int k = 0; k < dod_pkg::BCD_STEPS; k++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BW-2:0], n_bin[CBW-1]};
            n_bin = {n_bin[CBW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
            r_bcd_busy <= 1'b0;
            r_bcd_done <= 1'b0;
            r_bcd_cnt  <= '0;
        end else begin
            if (r_div_busy && !r_div_done) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == dod_pkg::DIV_CNT_W'(dod_pkg::DIV_ITERS - 1)) begin
                    r_div_done <= 1'b1;
                end
            end
            if (bcd_take) begin
                r_div_busy <= 1'b0;
                r_div_done <= 1'b0;
            end
            if (job_take) begin
                r_div_busy <= 1'b1;
                r_div_done <= 1'b0;
                r_div_cnt  <= '0;
            end

            if (r_bcd_busy && !r_bcd_done) begin
                r_bcd_cnt <= r_bcd_cnt + 1'b1;
                if (r_bcd_cnt == BCD_CNT_W'(BCD_ITERS - 1)) begin
                    r_bcd_done <= 1'b1;
                end
            end
            if (r_bcd_done && i_digits_ready) begin
                r_bcd_busy <= 1'b0;
                r_bcd_done <= 1'b0;
            end
            if (bcd_take) begin
                r_bcd_busy <= 1'b1;
                r_bcd_done <= 1'b0;
                r_bcd_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_rem <= '0;
            r_quo <= i_job.prod;
            r_den <= i_job.den;
            r_sat <= i_job.sat;
        end else if (r_div_busy && !r_div_done) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (bcd_take) begin
            r_bin <= CBW'(value);
            r_bcd <= '0;
        end else if (r_bcd_busy && !r_bcd_done) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

endmodule

// ===== rtl/core/dod_emit.sv =====
// Character sequencer: significant digits, then the fixed suffix, into an output register.
module dod_emit #(
    parameter int MAX_DIGITS = dod_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_digits_valid,
    output logic                         o_digits_ready,
    input  logic [4*MAX_DIGITS-1:0]      i_digits,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dod_pkg::CHAR_W-1:0]   o_char_code,
    output logic                         o_last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + dod_pkg::TAIL_LEN);
    localparam int DIW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] TAIL_TOP = CNT_W'(dod_pkg::TAIL_LEN);

    logic                         r_busy;
    logic [4*MAX_DIGITS-1:0]      r_digits;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_o_valid;
    logic [dod_pkg::CHAR_W-1:0]   r_char;
    logic                         r_last;
    logic                         adv;
    logic                         take;
    logic [CNT_W-1:0]             start_cnt;
    logic [DIW-1:0]               dig_idx;
    logic [dod_pkg::CHAR_W-1:0]   n_char;

    assign adv            = r_busy && (!r_o_valid || i_ready);
    assign o_digits_ready = !r_busy || (adv && r_cnt == '0);
    assign take           = i_digits_valid && o_digits_ready;

    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // Start at the highest nonzero digit; a zero value still shows one digit
    always_comb begin
        start_cnt = TAIL_TOP;
        for (int d = 1; d < MAX_DIGITS; d++) begin
            if (i_digits[4*d +: 4] != 4'd0) begin
                start_cnt = CNT_W'(d) + TAIL_TOP;
            end
        end
    end

    assign dig_idx = DIW'(r_cnt - TAIL_TOP);

    always_comb begin
        if (r_cnt >= TAIL_TOP) begin
            n_char = dod_pkg::CHAR_ZERO + dod_pkg::CHAR_W'(r_digits[4*dig_idx +: 4]);
        end else begin
            n_char = dod_pkg::tail_char(3'(TAIL_TOP - 1'b1 - r_cnt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_o_valid <= 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= start_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char <= n_char;
            r_last <= r_cnt == '0;
        end
        if (take) begin
            r_digits <= i_digits;
        end
    end

endmodule

// ===== rtl/core/divider_ohmmeter_decimal_display.sv =====
// Top level of the divider ohmmeter: configuration registers and the front/back pipeline.
//
// Usage: present one ADC sample per request on i_sample with i_valid; it is taken
// when o_ready is also high. The block answers with a stream of display characters
// on o_char_code, one per o_valid/i_ready request: the decimal digits of
// floor(v*reference/(supply-v)) ohms with no leading zeros, then ".00 " and the
// ohm sign (244), where o_last marks the ohm sign. Readings at or beyond the largest
// MAX_DIGITS-digit value, or with v at or above the supply, show as all nines.
// The user must write registers through i_cfg_we/i_cfg_index/i_cfg_data only while
// idle; the block itself does not enforce it. The sample rate is bound by the
// 4-bit-per-cycle divider or by the one-character-per-cycle output, whichever is
// slower. Reset empties every stage and the queue and loads the register reset
// values. When the receiver stalls, the output register holds its character, the
// digit sequencer, converter and divider back up, and the four-entry queue keeps
// absorbing samples until it fills; once the front stages also fill, o_ready drops.
module divider_ohmmeter_decimal_display #(
    parameter int SAMPLE_BITS = dod_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_DIGITS  = dod_pkg::MAX_DIGITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dod_pkg::CHAR_W-1:0]       o_char_code,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [dod_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dod_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [dod_pkg::REF_W-1:0]   r_reference_ohms;
    logic [dod_pkg::VPC_W-1:0]   r_volts_per_count;
    logic [dod_pkg::SUP_W-1:0]   r_supply_level;

    logic                        fr_valid;
    logic                        fr_ready;
    dod_pkg::t_job               fr_job;
    logic                        q_valid;
    logic                        q_ready;
    dod_pkg::t_job               q_job;
    logic                        dig_valid;
    logic                        dig_ready;
    logic [4*MAX_DIGITS-1:0]     dig_bcd;

    // Register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference_ohms  <= dod_pkg::RESET_REFERENCE_OHMS;
            r_volts_per_count <= dod_pkg::RESET_VOLTS_PER_COUNT;
            r_supply_level    <= dod_pkg::RESET_SUPPLY_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dod_pkg::REG_REFERENCE_OHMS:  r_reference_ohms  <= i_cfg_data[dod_pkg::REF_W-1:0];
                dod_pkg::REG_VOLTS_PER_COUNT: r_volts_per_count <= i_cfg_data[dod_pkg::VPC_W-1:0];
                dod_pkg::REG_SUPPLY_LEVEL:    r_supply_level    <= i_cfg_data[dod_pkg::SUP_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: sample voltage, then numerator and denominator
    dod_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_reference_ohms  (r_reference_ohms),
        .i_volts_per_count (r_volts_per_count),
        .i_supply_level    (r_supply_level),
        .o_job_valid       (fr_valid),
        .i_job_ready       (fr_ready),
        .o_job             (fr_job)
    );

    // Decouple front from the multi-cycle back end
    dod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_job   (fr_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    // Back: divide, clamp, convert to BCD
    dod_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .o_job_ready    (q_ready),
        .i_job          (q_job),
        .o_digits_valid (dig_valid),
        .i_digits_ready (dig_ready),
        .o_digits       (dig_bcd)
    );

    // Sequence characters into the output register
    dod_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_digits_valid (dig_valid),
        .o_digits_ready (dig_ready),
        .i_digits       (dig_bcd),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_code    (o_char_code),
        .o_last         (o_last)
    );

endmodule
